/* hw/rtl/calendar_date_advance_defines.svh */
// Assertion macros shared by the calendar date advance RTL.
`ifndef CALENDAR_DATE_ADVANCE_DEFINES_SVH
`define CALENDAR_DATE_ADVANCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CDA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calendar date advance: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define CDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calendar date advance: next-cycle check failed");

`endif

/* hw/rtl/cda_pkg.sv */
// Types, constants and month table for the calendar date advance block.
`default_nettype none

package cda_pkg;

   // Default year width.
   localparam int YEAR_BITS_DEF = 14;

   // Request kinds; the fourth code returns the date unchanged.
   typedef enum logic [1:0] {
      REQ_DAY   = 2'd0,
      REQ_MONTH = 2'd1,
      REQ_YEAR  = 2'd2
   } req_kind_type;

   // Month codes used by the rollover and clamp logic.
   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_MAR = 4'd3;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_MAY = 4'd5;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_JUL = 4'd7;
   localparam logic [3:0] MONTH_AUG = 4'd8;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_OCT = 4'd10;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // Day lengths.
   localparam logic [4:0] DAY_FIRST = 5'd1;
   localparam logic [4:0] DAY_FEB   = 5'd28;
   localparam logic [4:0] DAY_LEAP  = 5'd29;
   localparam logic [4:0] DAY_SHORT = 5'd30;
   localparam logic [4:0] DAY_LONG  = 5'd31;

   // Year mod 25 folding: weights of 256^i mod 25, then 256 and 32 mod 25.
   localparam int          MAX_BYTES   = 4;
   localparam logic [4:0]  BYTE_WEIGHT [MAX_BYTES] = '{5'd1, 5'd6, 5'd11, 5'd16};
   localparam int          SUM_W       = 14;
   localparam int          FOLD_W      = 9;
   localparam int          RES_W       = 8;
   localparam logic [2:0]  W256_MOD25  = 3'd6;
   localparam logic [2:0]  W32_MOD25   = 3'd7;
   localparam int          LEAP_MOD    = 25;
   localparam int          FOLD_MULTS  = 6;

   // Month length without the leap day; codes outside 1..12 count as January.
   function automatic logic [4:0] base_month_len(input logic [3:0] m);
      logic [4:0] len;
      case (m)
         MONTH_JAN: len = DAY_LONG;
         MONTH_FEB: len = DAY_FEB;
         MONTH_MAR: len = DAY_LONG;
         MONTH_APR: len = DAY_SHORT;
         MONTH_MAY: len = DAY_LONG;
         MONTH_JUN: len = DAY_SHORT;
         MONTH_JUL: len = DAY_LONG;
         MONTH_AUG: len = DAY_LONG;
         MONTH_SEP: len = DAY_SHORT;
         MONTH_OCT: len = DAY_LONG;
         MONTH_NOV: len = DAY_SHORT;
         MONTH_DEC: len = DAY_LONG;
         default:   len = DAY_LONG;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/calendar_date_advance.sv */
// Top level of the calendar date advance pipeline.
`default_nettype none
`include "calendar_date_advance_defines.svh"

// Advances a Gregorian date by one day, one month or one year. A request beat
// is taken on every clock edge where start is high; busy is always low, so a
// new date may enter every cycle. The result leaves the last register stage
// on rsp_valid for exactly one cycle, and must be taken then:
// there is no back-pressure on the result side. The four register stages are
// a weighted byte sum of the year, a fold of that sum toward mod 25, the leap
// decision with the year increment, and the final date selection.
module calendar_date_advance
   import cda_pkg::*;
#(
   parameter int YEAR_BITS = YEAR_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_type,
   input  wire logic [YEAR_BITS-1:0] req_year_in,
   input  wire logic [3:0]           req_month_in,
   input  wire logic [4:0]           req_day_in,
   output logic                      rsp_valid,
   output logic [YEAR_BITS-1:0]      rsp_year_out,
   output logic [3:0]                rsp_month_out,
   output logic [4:0]                rsp_day_out,
   output logic                      rsp_year_overflow
);

   localparam int NUM_BYTES = (YEAR_BITS + 7) / 8;
   localparam int PAD_W     = NUM_BYTES * 8;

   logic accept;

   // Stage 1 registers
   logic                 v1_ff;
   req_kind_type         kind1_ff;
   logic [YEAR_BITS-1:0] y1_ff;
   logic [3:0]           m1_ff;
   logic [4:0]           d1_ff;
   logic [SUM_W-1:0]     s1_ff, s1_in;

   // Stage 2 registers
   logic                 v2_ff;
   req_kind_type         kind2_ff;
   logic [YEAR_BITS-1:0] y2_ff;
   logic [3:0]           m2_ff;
   logic [4:0]           d2_ff;
   logic [FOLD_W-1:0]    t2_ff, t2_in;

   // Stage 3 registers
   logic                 v3_ff;
   req_kind_type         kind3_ff;
   logic [YEAR_BITS-1:0] y3_ff;
   logic [3:0]           m3_ff;
   logic [4:0]           d3_ff;
   logic                 leap3_ff, leap3_in;
   logic [YEAR_BITS-1:0] yinc3_ff, yinc3_in;
   logic                 carry3_ff, carry3_in;

   // Stage 4 (output) registers
   logic                 valid_ff;
   logic [YEAR_BITS-1:0] year_ff, year_in;
   logic [3:0]           month_ff, month_in;
   logic [4:0]           day_ff, day_in;
   logic                 ovf_ff, ovf_in;

   logic [RES_W-1:0]     u3;
   logic                 m25_zero;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Sum year bytes weighted by 256^i mod 25
   always_comb begin
      logic [PAD_W-1:0] y_pad;
      logic [SUM_W-1:0] acc;
      y_pad = PAD_W'(req_year_in);
      acc   = '0;
      for (int i = 0; i < NUM_BYTES; i++) begin
         acc = acc + SUM_W'(y_pad[i*8 +: 8]) * SUM_W'(BYTE_WEIGHT[i]);
      end
      s1_in = acc;
   end

   // Fold the bits above the low byte of the sum down again
   assign t2_in = FOLD_W'(s1_ff[7:0]) + FOLD_W'(s1_ff[SUM_W-1:8]) * FOLD_W'(W256_MOD25);

   // Fold to a value below 130 and test it against multiples of 25
   assign u3 = RES_W'(t2_ff[4:0]) + RES_W'(t2_ff[FOLD_W-1:5]) * RES_W'(W32_MOD25);

   always_comb begin
      m25_zero = 1'b0;
      for (int k = 0; k < FOLD_MULTS; k++) begin
         if (u3 == RES_W'(LEAP_MOD * k)) begin
            m25_zero = 1'b1;
         end
      end
   end

   // Leap: divisible by 4, and not by 100 unless by 400
   assign leap3_in  = (y2_ff[1:0] == 2'b00) && (!m25_zero || (y2_ff[3:0] == 4'b0000));
   assign yinc3_in  = y2_ff + YEAR_BITS'(1);
   assign carry3_in = &y2_ff;

   // Select the advanced date
   always_comb begin
      logic [4:0] maxd;
      logic [5:0] dinc;
      logic [4:0] mt;
      maxd     = base_month_len(m3_ff) + 5'((m3_ff == MONTH_FEB) && leap3_ff);
      dinc     = {1'b0, d3_ff} + 6'd1;
      mt       = {1'b0, m3_ff};
      year_in  = y3_ff;
      month_in = m3_ff;
      day_in   = d3_ff;
      ovf_in   = 1'b0;
      case (kind3_ff)
         REQ_DAY: begin
            if (dinc > {1'b0, maxd}) begin
               day_in = DAY_FIRST;
               mt     = {1'b0, m3_ff} + 5'd1;
            end else begin
               day_in = dinc[4:0];
            end
            if (mt > {1'b0, MONTH_DEC}) begin
               month_in = MONTH_JAN;
               year_in  = yinc3_ff;
               ovf_in   = carry3_ff;
            end else begin
               month_in = mt[3:0];
            end
         end
         REQ_MONTH: begin
            if (m3_ff >= MONTH_DEC) begin
               month_in = MONTH_JAN;
               year_in  = yinc3_ff;
               ovf_in   = carry3_ff;
            end else begin
               month_in = m3_ff + 4'd1;
            end
            if (month_in == MONTH_FEB) begin
               if (d3_ff > DAY_FEB) begin
                  day_in = leap3_ff ? DAY_LEAP : DAY_FEB;
               end
            end else if (month_in == MONTH_APR || month_in == MONTH_JUN ||
                         month_in == MONTH_SEP || month_in == MONTH_NOV) begin
               if (d3_ff > DAY_SHORT) begin
                  day_in = DAY_SHORT;
               end
            end
         end
         REQ_YEAR: begin
            year_in = yinc3_ff;
            ovf_in  = carry3_ff;
         end
         default: begin
         end
      endcase
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         v1_ff    <= accept;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         valid_ff <= v3_ff;
      end
   end

   // Advance payload through the stages
   always_ff @(posedge clock) begin
      kind1_ff  <= req_kind_type'(req_type);
      y1_ff     <= req_year_in;
      m1_ff     <= req_month_in;
      d1_ff     <= req_day_in;
      s1_ff     <= s1_in;

      kind2_ff  <= kind1_ff;
      y2_ff     <= y1_ff;
      m2_ff     <= m1_ff;
      d2_ff     <= d1_ff;
      t2_ff     <= t2_in;

      kind3_ff  <= kind2_ff;
      y3_ff     <= y2_ff;
      m3_ff     <= m2_ff;
      d3_ff     <= d2_ff;
      leap3_ff  <= leap3_in;
      yinc3_ff  <= yinc3_in;
      carry3_ff <= carry3_in;

      year_ff   <= year_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      ovf_ff    <= ovf_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_year_out      = year_ff;
   assign rsp_month_out     = month_ff;
   assign rsp_day_out       = day_ff;
   assign rsp_year_overflow = ovf_ff;

   // Checks
   `CDA_ASSERT_IMPLY(a_rsp_from_req, clock, reset, valid_ff, $past(start, 4))
   `CDA_ASSERT_IMPLY(a_ovf_year_zero, clock, reset, valid_ff && ovf_ff, year_ff == '0)
   `CDA_ASSERT_IMPLY(a_leap_div4, clock, reset, v3_ff && leap3_ff, y3_ff[1:0] == 2'b00)

endmodule

`default_nettype wire
